>>> sv/dssm_pkg.sv
package dssm_pkg;

    localparam int CNT_W  = 11;
    localparam int CAP_W  = 11;
    localparam int WORD_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Register index as decoded from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        FUNC_PUSH     = 2'd0,
        FUNC_POP      = 2'd1,
        FUNC_PEEK     = 2'd2,
        FUNC_IS_EMPTY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    stack_empty;
        logic    rd_op;
    } t_dec;

endpackage

>>> sv/dssm_ram.sv
module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/dssm_ctrl.sv
module dssm_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  dssm_pkg::t_func               i_func,
    input  logic                          i_which_stack,
    input  logic [dssm_pkg::CAP_W-1:0]    i_capacity,
    output dssm_pkg::t_dec                o_dec,
    output logic                          o_mem_en,
    output logic                          o_mem_we,
    output logic [$clog2(DEPTH)-1:0]      o_mem_addr
);

    import dssm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int BW = ((AW > CNT_W) ? AW : CNT_W) + 2;
    localparam logic [BW-1:0] DEPTH_X  = BW'(DEPTH);
    localparam logic [BW-1:0] DEPTH2_X = BW'(2 * DEPTH);

    logic [CNT_W-1:0] r_low_cnt;
    logic [CNT_W-1:0] r_high_cnt;
    logic [CNT_W-1:0] n_low_cnt;
    logic [CNT_W-1:0] n_high_cnt;

    logic [BW-1:0]    cap_x;
    logic [BW-1:0]    cap_used;
    logic [BW-1:0]    cnt_sum;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_next;
    logic             full;
    logic             empty_now;
    logic             do_write;
    logic             do_read;
    t_status          status;
    logic [BW-1:0]    addr_cnt;
    logic [BW-1:0]    low_addr;
    logic [BW-1:0]    hi_off;
    logic [BW-1:0]    hi_x;
    logic [BW-1:0]    hi_addr;

    always_comb begin
        cap_x     = BW'(i_capacity);
        cap_used  = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
        cnt_sum   = BW'(r_low_cnt) + BW'(r_high_cnt);
        cnt       = i_which_stack ? r_high_cnt : r_low_cnt;
        full      = (cnt_sum >= cap_used);
        empty_now = (cnt == '0);
        cnt_next  = cnt;
        do_write  = 1'b0;
        do_read   = 1'b0;
        status    = ST_OK;
        case (i_func)
            FUNC_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cnt_next = cnt + 1'b1;
                    do_write = 1'b1;
                end
            end
            FUNC_POP: begin
                if (empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    cnt_next = cnt - 1'b1;
                    do_read  = 1'b1;
                end
            end
            FUNC_PEEK: begin
                if (empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    do_read = 1'b1;
                end
            end
            FUNC_IS_EMPTY: begin
                status = ST_OK;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // A push addresses the entry of the new top, a pop or peek the current top.
    // Counts never exceed DEPTH, so one or two conditional subtractions wrap
    // the downward stack's address into the memory.
    always_comb begin
        addr_cnt = do_write ? BW'(cnt_next) : BW'(cnt);
        low_addr = addr_cnt - 1'b1;
        hi_off   = (addr_cnt == DEPTH_X) ? '0 : addr_cnt;
        hi_x     = cap_used + DEPTH_X - hi_off;
        if (hi_x >= DEPTH2_X) begin
            hi_addr = hi_x - DEPTH2_X;
        end else if (hi_x >= DEPTH_X) begin
            hi_addr = hi_x - DEPTH_X;
        end else begin
            hi_addr = hi_x;
        end
    end

    always_comb begin
        n_low_cnt  = r_low_cnt;
        n_high_cnt = r_high_cnt;
        if (i_accept) begin
            if (i_which_stack) begin
                n_high_cnt = cnt_next;
            end else begin
                n_low_cnt = cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
        end else begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
        end
    end

    assign o_mem_en          = i_accept && (do_write || do_read);
    assign o_mem_we          = do_write;
    assign o_mem_addr        = i_which_stack ? hi_addr[AW-1:0] : low_addr[AW-1:0];
    assign o_dec.status      = status;
    assign o_dec.stack_empty = (cnt_next == '0);
    assign o_dec.rd_op       = do_read;

    a_counts_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_sum <= DEPTH_X)
        else $error("stack counts exceed the memory depth");

    a_low_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_func == FUNC_PUSH) && !full && !i_which_stack
        |=> r_low_cnt == CNT_W'($past(r_low_cnt) + 1'b1))
        else $error("accepted push did not advance the upward stack count");

endmodule

>>> sv/dual_stack_shared_memory.sv
// Pipeline: a request transfer fills stage one, which waits for the read data;
// the result is then registered into the output stage and offered from there.
// Throughput: one request per cycle while results are taken; each request
// makes at most one access to the single-port memory, which sets that rate.
// Reset: both stack counts clear and the capacity returns to 1024. Memory contents
// are not cleared; read an entry only after pushing it (the block does not enforce it).
module dual_stack_shared_memory #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [31:0] push_value
    input  logic [2:0]                      s_axis_tuser,  // [1:0] func, [2] which_stack
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // [31:0] read_value
    output logic [2:0]                      m_axis_tuser,  // [1:0] status, [2] stack_empty
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dssm_pkg::PADDR_W-1:0]    paddr,
    input  logic [dssm_pkg::PDATA_W-1:0]    pwdata,
    output logic [dssm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    import dssm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0]      r_capacity;
    logic [CAP_W-1:0]      n_capacity;
    logic                  r_s1_valid;
    logic                  n_s1_valid;
    t_dec                  r_s1_dec;
    logic                  r_o_valid;
    logic                  n_o_valid;
    t_status               r_o_status;
    logic                  r_o_empty;
    logic [WORD_W-1:0]     r_o_value;

    logic                  accept;
    logic                  s1_adv;
    logic                  cfg_write;
    t_dec                  dec;
    logic                  mem_en;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [WORD_W-1:0]     rd_word;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(r_capacity) : '0;

    always_comb begin
        n_capacity = r_capacity;
        if (cfg_write) begin
            n_capacity = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    // Request side: decisions and the memory access happen at the transfer.
    assign s1_adv        = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    generate
        if (DATA_WIDTH >= WORD_W) begin : g_wide
            assign mem_wdata = DATA_WIDTH'(s_axis_tdata);
            assign rd_word   = mem_rdata[WORD_W-1:0];
        end else begin : g_narrow
            assign mem_wdata = s_axis_tdata[DATA_WIDTH-1:0];
            assign rd_word   = WORD_W'(mem_rdata);
        end
    endgenerate

    dssm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (t_func'(s_axis_tuser[1:0])),
        .i_which_stack (s_axis_tuser[2]),
        .i_capacity    (r_capacity),
        .o_dec         (dec),
        .o_mem_en      (mem_en),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr)
    );

    dssm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Stage one waits for the read data; the RAM output holds while it stalls
    // because no new request is taken then.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (r_s1_valid && s1_adv) begin
            n_o_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dec <= dec;
        end
        if (r_s1_valid && s1_adv) begin
            r_o_status <= r_s1_dec.status;
            r_o_empty  <= r_s1_dec.stack_empty;
            r_o_value  <= r_s1_dec.rd_op ? rd_word : '0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_value;
    assign m_axis_tuser  = {r_o_empty, r_o_status};

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request did not reach the first stage");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_o_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while both stages are held");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_status != ST_OK) |-> r_o_value == '0)
        else $error("refused request carries a nonzero read value");

endmodule

>>> verif/dual_stack_shared_memory_tb.sv
module dual_stack_shared_memory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dssm_pkg::*;

    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned BIG_PHASE   = 6;
    localparam int unsigned NUM_PHASES  = 9;
    localparam int unsigned NUM_ROWS    = 25;
    localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic        stack_empty;
    } t_stack_result;

    typedef struct packed {
        t_func         func;
        logic          stk;
        logic [31:0]   value;
        logic          typed;
        t_stack_result result;
    } t_directed_row;

    typedef struct packed {
        logic [31:0] wdata;
        int          items;
        int          push_pct;
        int          pop_pct;
        int          peek_pct;
    } t_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;   // [31:0] push_value
    logic [2:0]          s_axis_tuser;   // [1:0] func, [2] which_stack
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;   // [31:0] read_value
    logic [2:0]          m_axis_tuser;   // [1:0] status, [2] stack_empty
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state.
    logic [31:0]         store_image [STORE_DEPTH];
    bit                  written [STORE_DEPTH];
    logic [CNT_W-1:0]    low_cnt;
    logic [CNT_W-1:0]    high_cnt;
    logic [CAP_W-1:0]    cap_reg;

    t_stack_result       expected_q [$];
    t_stack_result       oldest;
    int unsigned         err_count;
    int unsigned         results_seen;
    int unsigned         stall_cycles;
    int unsigned         hold_left;
    bit                  hold_request;
    bit                  hold_started;
    bit                  quiet;

    t_directed_row directed_rows [NUM_ROWS] = '{
        '{FUNC_IS_EMPTY, 1'b0, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 1'b1}},
        '{FUNC_IS_EMPTY, 1'b1, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 1'b1}},
        '{FUNC_POP,      1'b0, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 1'b1}},
        '{FUNC_PEEK,     1'b0, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 1'b1}},
        '{FUNC_POP,      1'b1, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 1'b1}},
        '{FUNC_PEEK,     1'b1, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 1'b1}},
        '{FUNC_PUSH,     1'b0, 32'h7FFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_PUSH,     1'b1, 32'h8000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_PEEK,     1'b0, 32'h0000_0000, 1'b1, '{ST_OK,    32'h7FFF_FFFF, 1'b0}},
        '{FUNC_PEEK,     1'b1, 32'h0000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 1'b0}},
        '{FUNC_PUSH,     1'b0, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_PUSH,     1'b1, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_POP,      1'b0, 32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 1'b0}},
        '{FUNC_POP,      1'b0, 32'h0000_0000, 1'b1, '{ST_OK,    32'h7FFF_FFFF, 1'b1}},
        '{FUNC_POP,      1'b1, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_POP,      1'b1, 32'h0000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 1'b1}},
        '{FUNC_PUSH,     1'b0, 32'hA5A5_A5A5, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_POP,      1'b0, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_PUSH,     1'b1, 32'h5A5A_5A5A, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_PEEK,     1'b1, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_IS_EMPTY, 1'b1, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_PUSH,     1'b1, 32'h0000_0001, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_POP,      1'b1, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_POP,      1'b1, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}},
        '{FUNC_IS_EMPTY, 1'b0, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 1'b0}}
    };

    // Capacity zero is written with bit 11 set and the clamp case with all ones,
    // so the unused upper bits of pwdata are exercised as well.
    t_phase phases [NUM_PHASES] = '{
        '{32'd4,          30,   45, 25, 15},
        '{32'd1,          20,   45, 25, 15},
        '{32'h0000_0800,  20,   40, 35, 15},
        '{32'd16,         30,   65, 15, 10},
        '{32'd3,          30,   30, 40, 15},
        '{32'd2,          20,   40, 30, 15},
        '{32'hFFFF_FFFF,  1060, 99, 1,  0},
        '{32'd1024,       30,   30, 45, 15},
        '{32'd5,          30,   30, 45, 15}
    };

    dual_stack_shared_memory #(
        .DEPTH      (STORE_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int unsigned usable_capacity();
        return (cap_reg > STORE_DEPTH) ? STORE_DEPTH : int'(cap_reg);
    endfunction

    function automatic int unsigned top_entry(logic stk);
        if (!stk) begin
            return (int'(low_cnt) + STORE_DEPTH - 1) % STORE_DEPTH;
        end
        return (usable_capacity() + STORE_DEPTH - (int'(high_cnt) % STORE_DEPTH)) % STORE_DEPTH;
    endfunction

    // Applies one request to the stack image and returns the result it yields.
    function automatic t_stack_result stack_apply(t_func f, logic stk, logic [31:0] v);
        t_stack_result    r;
        logic [CNT_W-1:0] cnt;
        int unsigned      entry;
        r = '{ST_OK, 32'h0, 1'b0};
        cnt = stk ? high_cnt : low_cnt;
        case (f)
            FUNC_PUSH: begin
                if (int'(low_cnt) + int'(high_cnt) >= usable_capacity()) begin
                    r.status = ST_FULL;
                end else begin
                    if (stk) high_cnt = high_cnt + 1'b1;
                    else low_cnt = low_cnt + 1'b1;
                    entry = top_entry(stk);
                    store_image[entry] = v;
                    written[entry] = 1'b1;
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = store_image[top_entry(stk)];
                    if (f == FUNC_POP) begin
                        if (stk) high_cnt = high_cnt - 1'b1;
                        else low_cnt = low_cnt - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.stack_empty = ((stk ? high_cnt : low_cnt) == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < 40) begin
            $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        end
        err_count++;
    endtask

    // Offers one request, waits for its transfer, then records the expected result.
    task automatic send_request(t_func f, logic stk, logic [31:0] v, logic typed,
                                t_stack_result typed_res);
        t_stack_result res;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= {stk, f};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = stack_apply(f, stk, v);
        expected_q.push_back(typed ? typed_res : res);
    endtask

    task automatic send_random(int push_pct, int pop_pct, int peek_pct);
        int unsigned      r;
        t_func            f;
        logic             stk;
        logic [31:0]      v;
        logic [CNT_W-1:0] cnt;
        r = $urandom_range(99);
        if (r < push_pct) f = FUNC_PUSH;
        else if (r < push_pct + pop_pct) f = FUNC_POP;
        else if (r < push_pct + pop_pct + peek_pct) f = FUNC_PEEK;
        else f = FUNC_IS_EMPTY;
        stk = 1'($urandom_range(1));
        v = $urandom;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: v = 32'h0000_0000;
                1: v = 32'hFFFF_FFFF;
                2: v = 32'h8000_0000;
                default: v = 32'h7FFF_FFFF;
            endcase
        end
        // After a capacity change the top of the downward stack can move onto an
        // entry that was never written; such a read is turned into an emptiness test.
        cnt = stk ? high_cnt : low_cnt;
        if ((f == FUNC_POP || f == FUNC_PEEK) && cnt != 0 && !written[top_entry(stk)]) begin
            f = FUNC_IS_EMPTY;
        end
        send_request(f, stk, v, 1'b0, '{ST_OK, 32'h0, 1'b0});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_reg = value[CAP_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_capacity();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(PDATA_W-CAP_W){1'b0}}, cap_reg}) begin
            report_mismatch("capacity readback", prdata, {{(PDATA_W-CAP_W){1'b0}}, cap_reg});
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold-off that fills the block.
    always @(negedge i_clk) begin
        if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata, 32'h0);
            end else begin
                oldest = expected_q.pop_front();
                if (m_axis_tuser[1:0] !== oldest.status) begin
                    report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(oldest.status));
                end
                if (m_axis_tdata !== oldest.read_value) begin
                    report_mismatch("read_value", m_axis_tdata, oldest.read_value);
                end
                if (m_axis_tuser[2] !== oldest.stack_empty) begin
                    report_mismatch("stack_empty", 32'(m_axis_tuser[2]), 32'(oldest.stack_empty));
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_count     = 0;
        results_seen  = 0;
        stall_cycles  = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        hold_started  = 1'b0;
        quiet         = 1'b0;
        low_cnt       = '0;
        high_cnt      = '0;
        cap_reg       = CAP_RESET;
        foreach (written[i]) written[i] = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_capacity();
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_request(directed_rows[i].func, directed_rows[i].stk, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].result);
        end

        // Stacks are not drained between phases, so lowering the capacity
        // leaves counts above it and exercises the refused-push path.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_capacity(phases[p].wdata);
            check_capacity();
            for (int n = 0; n < phases[p].items; n++) begin
                quiet = (p == BIG_PHASE) && (n >= 300) && (n < 600);
                if (p == BIG_PHASE && n == 100) hold_request = 1'b1;
                send_random(phases[p].push_pct, phases[p].pop_pct, phases[p].peek_pct);
            end
            quiet = 1'b0;
        end

        wait_idle();
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
